@@ rtl/xcfr_pkg.sv @@
// Shared types and constants for the XOR-checked command frame receiver.
`default_nettype none

package xcfr_pkg;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    // Register byte addresses
    localparam logic [APB_ADDR_W-1:0] REG_HEADER_ADDR = 2'd0;

    // Reset value of the header register
    localparam logic [7:0] HEADER_RESET = 8'hAA;

    // Frame parser states, one-hot
    typedef enum logic [6:0] {
        ST_HUNT   = 7'b0000001,
        ST_CMD    = 7'b0000010,
        ST_CUR_HI = 7'b0000100,
        ST_CUR_LO = 7'b0001000,
        ST_ANG_HI = 7'b0010000,
        ST_ANG_LO = 7'b0100000,
        ST_CSUM   = 7'b1000000
    } parse_state_t;

endpackage

`default_nettype wire

@@ rtl/xor_checked_command_frame_receiver.sv @@
// Top level of the XOR-checked command frame receiver: byte parser and result register.
//
// Usage: received bytes enter on the in_valid/in_ready channel (rx_byte), one
// byte per transfer. The parser hunts for the header byte, then collects
// command, current reference (signed, big endian), angle (big endian) and a
// checksum byte. On the checksum byte one result leaves on the
// out_valid/out_ready channel: frame_ok, decoded fields and the wrapping good
// and bad frame counts including this frame. No other byte gives a result.
// The header byte is set through the APB port (register 0, address 0).
// Order: a byte is taken into the input register and parsed from there; a
// checksum byte's result is then registered in the output register.
// Throughput: one byte per cycle while no checksum byte is held, set by the
// parse step between the input register and the result register.
// Stall: a result waits in the output register while out_ready is low; the
// parser keeps taking bytes until a second checksum byte needs that register,
// then it holds it in the input register and in_ready falls.
// Reset: rst_n clears the parser to header hunting, the counters to zero,
// both valid flags, and sets the header register to 0xAA.
`default_nettype none

module xor_checked_command_frame_receiver (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // APB configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [xcfr_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [xcfr_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [xcfr_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                        pready,
    // Byte input channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [7:0]                             rx_byte,
    // Result channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        frame_ok,
    output logic [7:0]                                  command,
    output logic signed [15:0]                          current_ref,
    output logic [15:0]                                 angle,
    output logic [15:0]                                 good_frames,
    output logic [15:0]                                 bad_frames
);

    // Configuration register
    logic [7:0] header_reg;
    logic       cfg_write;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    xcfr_pkg::parse_state_t state_reg, state_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] ang_reg, ang_next;
    logic [15:0] good_cnt_reg, good_cnt_next;
    logic [15:0] bad_cnt_reg, bad_cnt_next;

    // Output stage
    logic        out_valid_reg;
    logic        frame_ok_reg;
    logic [7:0]  command_reg;
    logic [15:0] current_reg;
    logic [15:0] angle_reg;
    logic [15:0] good_frames_reg;
    logic [15:0] bad_frames_reg;

    // Control
    logic       advance;
    logic       parse_fire;
    logic       out_load;
    logic [7:0] csum;
    logic       csum_ok;

    // APB: single register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    always_comb
    begin
        prdata = '0;
        if (paddr == xcfr_pkg::REG_HEADER_ADDR)
        begin
            prdata[7:0] = header_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= xcfr_pkg::HEADER_RESET;
        end
        else if (cfg_write)
        begin
            header_reg <= pwdata[7:0];
        end
    end

    // Hold a checksum byte while the result register is still occupied
    assign advance    = (state_reg != xcfr_pkg::ST_CSUM) || !out_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || advance;
    assign parse_fire = in_valid_reg && advance;

    // Capture incoming byte transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Checksum over the five payload bytes
    assign csum    = cmd_reg ^ cur_reg[15:8] ^ cur_reg[7:0] ^ ang_reg[15:8] ^ ang_reg[7:0];
    assign csum_ok = (csum == in_byte_reg);

    // Parse step: advance the frame state on each byte
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cur_next      = cur_reg;
        ang_next      = ang_reg;
        good_cnt_next = good_cnt_reg;
        bad_cnt_next  = bad_cnt_reg;
        out_load      = 1'b0;
        if (parse_fire)
        begin
            case (state_reg)
                xcfr_pkg::ST_HUNT:
                begin
                    if (in_byte_reg == header_reg)
                    begin
                        state_next = xcfr_pkg::ST_CMD;
                    end
                end
                xcfr_pkg::ST_CMD:
                begin
                    cmd_next   = in_byte_reg;
                    state_next = xcfr_pkg::ST_CUR_HI;
                end
                xcfr_pkg::ST_CUR_HI:
                begin
                    cur_next   = {in_byte_reg, 8'h00};
                    state_next = xcfr_pkg::ST_CUR_LO;
                end
                xcfr_pkg::ST_CUR_LO:
                begin
                    cur_next   = {cur_reg[15:8], in_byte_reg};
                    state_next = xcfr_pkg::ST_ANG_HI;
                end
                xcfr_pkg::ST_ANG_HI:
                begin
                    ang_next   = {in_byte_reg, 8'h00};
                    state_next = xcfr_pkg::ST_ANG_LO;
                end
                xcfr_pkg::ST_ANG_LO:
                begin
                    ang_next   = {ang_reg[15:8], in_byte_reg};
                    state_next = xcfr_pkg::ST_CSUM;
                end
                xcfr_pkg::ST_CSUM:
                begin
                    if (csum_ok)
                    begin
                        good_cnt_next = good_cnt_reg + 16'd1;
                    end
                    else
                    begin
                        bad_cnt_next = bad_cnt_reg + 16'd1;
                    end
                    out_load   = 1'b1;
                    state_next = xcfr_pkg::ST_HUNT;
                end
                default:
                begin
                    state_next = xcfr_pkg::ST_HUNT;
                end
            endcase
        end
    end

    // Parser and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= xcfr_pkg::ST_HUNT;
            cmd_reg      <= '0;
            cur_reg      <= '0;
            ang_reg      <= '0;
            good_cnt_reg <= '0;
            bad_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            cur_reg      <= cur_next;
            ang_reg      <= ang_next;
            good_cnt_reg <= good_cnt_next;
            bad_cnt_reg  <= bad_cnt_next;
        end
    end

    // Result valid: set on load, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frame_ok_reg    <= csum_ok;
            command_reg     <= cmd_reg;
            current_reg     <= cur_reg;
            angle_reg       <= ang_reg;
            good_frames_reg <= good_cnt_next;
            bad_frames_reg  <= bad_cnt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = frame_ok_reg;
    assign command     = command_reg;
    assign current_ref = $signed(current_reg);
    assign angle       = angle_reg;
    assign good_frames = good_frames_reg;
    assign bad_frames  = bad_frames_reg;

`ifndef ASSERT_OFF
    // Exactly one counter moves per loaded result
    a_one_count_per_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (16'(good_cnt_reg + bad_cnt_reg)
                      == 16'($past(good_cnt_reg) + $past(bad_cnt_reg) + 16'd1)))
        else $error("frame counters did not advance by one on a result");

    // Counters stay put when no result is produced
    a_counts_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> ($stable(good_cnt_reg) && $stable(bad_cnt_reg)))
        else $error("frame counter moved without a result");

    // The flag matches the counter that moved
    a_flag_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (frame_ok_reg ? (good_cnt_reg != $past(good_cnt_reg))
                                   : (bad_cnt_reg != $past(bad_cnt_reg))))
        else $error("frame_ok disagrees with the counters");

    // A checksum byte facing a held result must stall the input
    a_stall_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (state_reg == xcfr_pkg::ST_CSUM) && out_valid_reg && !out_ready)
        |-> (!in_ready && !out_load))
        else $error("checksum byte processed while result register was full");
`endif

endmodule

`default_nettype wire
